>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compositor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define AFPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("afpc check failed");

// When trig holds, cons must hold at the next clock edge.
`define AFPC_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("afpc check failed");

`endif

>>> sv/afpc_pkg.sv
// ----------------------------------------------------------------------------
// afpc_pkg
// Types and constants shared by the animated frame pixel compositor.
// ----------------------------------------------------------------------------
package afpc_pkg;

	localparam int POS_W     = 14;
	localparam int SIZE_W    = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [SIZE_W-1:0] CANVAS_MAX = 15'd16384;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_RECT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREVIOUS_RECT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_FLAGS   = 3'd4;

	typedef struct packed {
		logic [15:0] height;
		logic [15:0] width;
		logic [15:0] top;
		logic [15:0] left;
	} rect_t;

	typedef struct packed {
		logic dispose_bg;
		logic blend;
		logic alpha_used;
		logic key;
	} frame_flags_t;

	typedef struct packed {
		rect_t        cur;
		rect_t        prv;
		frame_flags_t flags;
	} frame_cfg_t;

	typedef struct packed {
		logic [31:0] prev_pixel;
		logic [31:0] decoded_pixel;
	} pixel_in_t;

	typedef struct packed {
		logic [31:0] pixel_out;
		logic        last_pixel;
	} pixel_out_t;

endpackage

>>> sv/animated_frame_pixel_compositor.sv
// A pixel accepted into the input register is composed combinationally, then
// registered in the result register, which drives result.
// Throughput: one pixel per clock while not stalled by result_ready; the input
// register and the result register each move whenever the next stage is free.
// Reset clears the counters and pipeline valids and sets the canvas to 1x1,
// both rectangles and all frame flags to zero.
// ----------------------------------------------------------------------------
// animated_frame_pixel_compositor
// Raster-order canvas compositor for animated frames: one composed pixel
// per request, with configuration registers for canvas and frame geometry.
// ----------------------------------------------------------------------------
module animated_frame_pixel_compositor import afpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  pixel_in_t             pixel,
	output logic                  result_valid,
	input  logic                  result_ready,
	output pixel_out_t            result
);

	logic [SIZE_W-1:0] canvas_width_q, canvas_height_q;
	frame_cfg_t        frame_q;
	logic [POS_W-1:0]  col_q, row_q;

	logic              valid_s1;
	pixel_in_t         pixel_s1;
	logic [POS_W-1:0]  col_s1, row_s1;
	logic              last_s1;

	logic              out_valid_q;
	pixel_out_t        out_q;

	logic              out_free, s1_adv, accept;
	logic [SIZE_W-1:0] width_eff, height_eff, col_inc, row_inc;
	logic              line_end, canvas_end;
	logic [31:0]       composed;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= 15'd1;
			canvas_height_q <= 15'd1;
			frame_q         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data[SIZE_W-1:0];
				REG_CANVAS_HEIGHT: canvas_height_q <= cfg_data[SIZE_W-1:0];
				REG_CURRENT_RECT:  frame_q.cur     <= rect_t'(cfg_data);
				REG_PREVIOUS_RECT: frame_q.prv     <= rect_t'(cfg_data);
				REG_FRAME_FLAGS:   frame_q.flags   <= frame_flags_t'(cfg_data[3:0]);
				default: ;
			endcase
		end
	end

	// Handshake chain: result register, then input register.
	assign out_free    = !out_valid_q || result_ready;
	assign s1_adv      = valid_s1 && out_free;
	assign pixel_ready = !valid_s1 || out_free;
	assign accept      = pixel_valid && pixel_ready;

	// Size zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		if (canvas_width_q == '0) begin
			width_eff = 15'd1;
		end else if (canvas_width_q > CANVAS_MAX) begin
			width_eff = CANVAS_MAX;
		end else begin
			width_eff = canvas_width_q;
		end
		if (canvas_height_q == '0) begin
			height_eff = 15'd1;
		end else if (canvas_height_q > CANVAS_MAX) begin
			height_eff = CANVAS_MAX;
		end else begin
			height_eff = canvas_height_q;
		end
	end

	assign col_inc    = {1'b0, col_q} + 15'd1;
	assign row_inc    = {1'b0, row_q} + 15'd1;
	assign line_end   = col_inc >= width_eff;
	assign canvas_end = line_end && (row_inc >= height_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= canvas_end ? '0 : row_inc[POS_W-1:0];
			end else begin
				col_q <= col_inc[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			col_s1   <= col_q;
			row_s1   <= row_q;
			last_s1  <= canvas_end;
		end
	end

	afpc_compose u_compose (
		.frame         (frame_q),
		.col           (col_s1),
		.row           (row_s1),
		.prev_pixel    (pixel_s1.prev_pixel),
		.decoded_pixel (pixel_s1.decoded_pixel),
		.pixel_out     (composed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.pixel_out  <= composed;
			out_q.last_pixel <= last_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> sv/afpc_compose.sv
// ----------------------------------------------------------------------------
// afpc_compose
// Combinational composition of one canvas pixel from the previous canvas
// pixel, the decoded pixel and the frame rectangles at a given position.
// ----------------------------------------------------------------------------
module afpc_compose import afpc_pkg::*; (
	input  frame_cfg_t       frame,
	input  logic [POS_W-1:0] col,
	input  logic [POS_W-1:0] row,
	input  logic [31:0]      prev_pixel,
	input  logic [31:0]      decoded_pixel,
	output logic [31:0]      pixel_out
);

	logic [16:0] cur_right, cur_bottom, prv_right, prv_bottom;
	logic [16:0] col_x, row_x;
	logic        in_cur, in_prv, covered, zero_alpha;

	// Right and bottom edges carry one extra bit so they never wrap.
	assign cur_right  = {1'b0, frame.cur.left} + {1'b0, frame.cur.width};
	assign cur_bottom = {1'b0, frame.cur.top}  + {1'b0, frame.cur.height};
	assign prv_right  = {1'b0, frame.prv.left} + {1'b0, frame.prv.width};
	assign prv_bottom = {1'b0, frame.prv.top}  + {1'b0, frame.prv.height};

	assign col_x = {3'b000, col};
	assign row_x = {3'b000, row};

	assign in_cur = (col_x >= {1'b0, frame.cur.left}) && (col_x < cur_right) &&
	                (row_x >= {1'b0, frame.cur.top})  && (row_x < cur_bottom);
	assign in_prv = (col_x >= {1'b0, frame.prv.left}) && (col_x < prv_right) &&
	                (row_x >= {1'b0, frame.prv.top})  && (row_x < prv_bottom);

	assign covered = (!frame.flags.alpha_used || !frame.flags.blend) &&
	                 (frame.cur.left <= frame.prv.left) && (prv_right <= cur_right) &&
	                 (frame.cur.top <= frame.prv.top) && (prv_bottom <= cur_bottom);

	assign zero_alpha = (decoded_pixel[31:24] == 8'h00);

	always_comb begin
		if (frame.flags.key) begin
			pixel_out = 32'h0;
		end else if (frame.flags.dispose_bg && !covered && in_prv) begin
			pixel_out = 32'h0;
		end else begin
			pixel_out = prev_pixel;
		end
		if (in_cur) begin
			pixel_out = decoded_pixel;
			// Blended transparent pixel shows the old canvas unless key or disposed.
			if (frame.flags.blend && !frame.flags.key && zero_alpha &&
			    (!frame.flags.dispose_bg || !in_prv)) begin
				pixel_out = prev_pixel;
			end
		end
	end

endmodule

>>> sv/afpc_checker.sv
// ----------------------------------------------------------------------------
// afpc_checker
// Port-level checks for the compositor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afpc_checker import afpc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_ready,
	input logic       pixel_ready,
	input logic       result_valid,
	input logic       result_ready,
	input pixel_out_t result
);

	// Hold a stalled result and its payload.
	`AFPC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid)
	`AFPC_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && !result_ready, $stable(result))

	// An empty result register never backs up the pixel side.
	`AFPC_ASSERT_ALWAYS(a_ready_when_empty, clk, arst_n, result_valid || pixel_ready)

	// Register writes are never stalled.
	`AFPC_ASSERT_ALWAYS(a_cfg_ready, clk, arst_n, cfg_ready)

endmodule

bind animated_frame_pixel_compositor afpc_checker u_afpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_ready    (cfg_ready),
	.pixel_ready  (pixel_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel requests and register writes into the compositor, predicts
// each untyped composed pixel from a local model of the raster counters and
// frame geometry, and checks each result in order. A short table of directed
// cases is followed by randomized frame setups under several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import afpc_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int HOLDOFF_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_e;

	typedef struct {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		logic [31:0]           prev_px;
		logic [31:0]           dec_px;
		logic                  typed;
		pixel_out_t            want;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_ready;
	pixel_in_t             pixel = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	pixel_out_t            result;

	// typed expectation travelling with the request being offered
	logic       typed_valid = 1'b0;
	pixel_out_t typed_want = '0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_req = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int cycle_count = 0;
	int mismatch_count = 0;

	pixel_out_t    expected_pixels[$];
	directed_row_t directed_rows[$];

	// local copy of the compositor state
	logic [SIZE_W-1:0] canvas_w = 15'd1;
	logic [SIZE_W-1:0] canvas_h = 15'd1;
	rect_t             cur_rect = '0;
	rect_t             prv_rect = '0;
	frame_flags_t      flags = '0;
	logic [POS_W-1:0]  col_pos = '0;
	logic [POS_W-1:0]  row_pos = '0;

	animated_frame_pixel_compositor dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	function automatic logic [SIZE_W-1:0] clamp_canvas(input logic [SIZE_W-1:0] v);
		if (v == '0)
			return 15'd1;
		if (v > CANVAS_MAX)
			return CANVAS_MAX;
		return v;
	endfunction

	// compose the pixel at the current raster position and advance the position
	function automatic pixel_out_t compose_pixel(input logic [31:0] prev_px,
			input logic [31:0] dec_px);
		logic [16:0] w, h, x, y;
		logic [16:0] cur_right, cur_bottom, prv_right, prv_bottom;
		logic        in_cur, in_prv, covered, line_end, canvas_end;
		pixel_out_t  res;
		w = {2'b00, clamp_canvas(canvas_w)};
		h = {2'b00, clamp_canvas(canvas_h)};
		x = {3'b000, col_pos};
		y = {3'b000, row_pos};
		cur_right  = {1'b0, cur_rect.left} + {1'b0, cur_rect.width};
		cur_bottom = {1'b0, cur_rect.top} + {1'b0, cur_rect.height};
		prv_right  = {1'b0, prv_rect.left} + {1'b0, prv_rect.width};
		prv_bottom = {1'b0, prv_rect.top} + {1'b0, prv_rect.height};
		in_cur = x >= {1'b0, cur_rect.left} && x < cur_right &&
			y >= {1'b0, cur_rect.top} && y < cur_bottom;
		in_prv = x >= {1'b0, prv_rect.left} && x < prv_right &&
			y >= {1'b0, prv_rect.top} && y < prv_bottom;
		covered = (!flags.alpha_used || !flags.blend) &&
			cur_rect.left <= prv_rect.left && prv_right <= cur_right &&
			cur_rect.top <= prv_rect.top && prv_bottom <= cur_bottom;

		if (flags.key) begin
			res.pixel_out = '0;
		end else begin
			res.pixel_out = prev_px;
			if (flags.dispose_bg && !covered && in_prv)
				res.pixel_out = '0;
		end
		if (in_cur) begin
			res.pixel_out = dec_px;
			// transparent decoded pixel shows the old canvas, unless it was disposed
			if (flags.blend && !flags.key && dec_px[31:24] == 8'h00 &&
					(!flags.dispose_bg || !in_prv))
				res.pixel_out = prev_px;
		end

		line_end = x + 17'd1 >= w;
		canvas_end = line_end && (y + 17'd1 >= h);
		if (line_end) begin
			col_pos = '0;
			row_pos = canvas_end ? '0 : POS_W'(y + 17'd1);
		end else begin
			col_pos = POS_W'(x + 17'd1);
		end
		res.last_pixel = canvas_end;
		return res;
	endfunction

	// check results, track register writes and requests
	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("result with nothing pending", result.pixel_out, '0);
				end else begin
					want = expected_pixels.pop_front();
					if (result.pixel_out !== want.pixel_out)
						report_mismatch("pixel_out", result.pixel_out, want.pixel_out);
					if (result.last_pixel !== want.last_pixel)
						report_mismatch("last_pixel", 32'(result.last_pixel), 32'(want.last_pixel));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CANVAS_WIDTH:  canvas_w = cfg_data[SIZE_W-1:0];
					REG_CANVAS_HEIGHT: canvas_h = cfg_data[SIZE_W-1:0];
					REG_CURRENT_RECT:  cur_rect = cfg_data;
					REG_PREVIOUS_RECT: prv_rect = cfg_data;
					REG_FRAME_FLAGS:   flags = cfg_data[3:0];
					default: ;
				endcase
			end
			if (pixel_valid && pixel_ready) begin
				want = compose_pixel(pixel.prev_pixel, pixel.decoded_pixel);
				expected_pixels.push_back(typed_valid ? typed_want : want);
			end
		end
	end

	// receiver: a long holdoff on request, random stalls otherwise
	always @(posedge clk) begin
		if (holdoff_req != holdoff_seen) begin
			holdoff_seen = holdoff_req;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= $urandom_range(99) >= stall_pct;
		end
	end

	function automatic logic [63:0] pack_rect(input int left, top, w, h);
		rect_t r;
		r.left = 16'(left);
		r.top = 16'(top);
		r.width = 16'(w);
		r.height = 16'(h);
		return r;
	endfunction

	function automatic logic [63:0] mk_flags(input logic key, alpha, blend, dispose);
		frame_flags_t f;
		f.key = key;
		f.alpha_used = alpha;
		f.blend = blend;
		f.dispose_bg = dispose;
		return 64'(f);
	endfunction

	function automatic logic [63:0] random_rect(input int span_w, span_h);
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return '1;
			2: return pack_rect(0, 0, span_w, span_h);
			default: return pack_rect($urandom_range(0, span_w), $urandom_range(0, span_h),
				$urandom_range(0, span_w), $urandom_range(0, span_h));
		endcase
	endfunction

	task automatic add_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
		directed_rows.push_back('{ROW_REG, index, data, '0, '0, 1'b0, '0});
	endtask

	task automatic add_pixel(input logic [31:0] prev_px, dec_px, input logic typed,
			input logic [31:0] out_px, input logic last);
		pixel_out_t w;
		w.pixel_out = out_px;
		w.last_pixel = last;
		directed_rows.push_back('{ROW_PIXEL, '0, '0, prev_px, dec_px, typed, w});
	endtask

	// drop pixel valid and wait until every pending result is back
	task automatic drain();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [31:0] prev_px, dec_px, input logic typed,
			input pixel_out_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pixel_valid <= 1'b1;
		pixel <= '{prev_pixel: prev_px, decoded_pixel: dec_px};
		typed_valid <= typed;
		typed_want <= want;
		do @(posedge clk); while (!pixel_ready);
	endtask

	initial begin
		int            phase_idle[4];
		int            phase_stall[4];
		logic [14:0]   w_raw, h_raw;
		logic [63:0]   data, cur_r;
		logic [31:0]   prev_px, dec_px;
		int            span_w, span_h, n;

		phase_idle = '{0, 84, 0, 21};
		phase_stall = '{0, 0, 84, 21};

		// canvas is 1x1 after reset, so every pixel is the last one
		add_pixel(32'hDEADBEEF, 32'h12345678, 1'b1, 32'hDEADBEEF, 1'b1);
		add_pixel(32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1);
		add_pixel(32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b1);
		// key frame clears the canvas
		add_reg(REG_FRAME_FLAGS, mk_flags(1'b1, 1'b0, 1'b0, 1'b0));
		add_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b1);
		add_reg(REG_CURRENT_RECT, pack_rect(16'hFFFF, 0, 16'hFFFF, 16'hFFFF));
		add_reg(REG_CURRENT_RECT, pack_rect(0, 0, 16'hFFFF, 16'hFFFF));
		add_pixel(32'hFFFFFFFF, 32'h12345678, 1'b1, 32'h12345678, 1'b1);
		// blend: zero alpha keeps the old pixel, partial alpha passes through
		add_reg(REG_FRAME_FLAGS, mk_flags(1'b0, 1'b0, 1'b1, 1'b0));
		add_pixel(32'hAABBCCDD, 32'h00FFFFFF, 1'b1, 32'hAABBCCDD, 1'b1);
		add_pixel(32'hAABBCCDD, 32'h01000000, 1'b1, 32'h01000000, 1'b1);
		// blend under dispose-to-background inside the previous rectangle
		add_reg(REG_PREVIOUS_RECT, pack_rect(0, 0, 1, 1));
		add_reg(REG_FRAME_FLAGS, mk_flags(1'b0, 1'b1, 1'b1, 1'b1));
		add_pixel(32'hAABBCCDD, 32'h00FFFFFF, 1'b1, 32'h00FFFFFF, 1'b1);
		// dispose with the previous rectangle not covered, on a 3x2 canvas
		add_reg(REG_FRAME_FLAGS, mk_flags(1'b0, 1'b0, 1'b0, 1'b1));
		add_reg(REG_CURRENT_RECT, pack_rect(1, 0, 1, 1));
		add_reg(REG_PREVIOUS_RECT, pack_rect(0, 0, 2, 2));
		add_reg(REG_CANVAS_WIDTH, 64'd3);
		add_reg(REG_CANVAS_HEIGHT, 64'd2);
		add_reg(REG_UNMAPPED, '1);
		for (int k = 0; k < 6; k++)
			add_pixel(32'h11223344 * (k + 1), 32'h80706050 + k, 1'b0, '0, 1'b0);
		// zero width acts as one, oversized height clamps
		add_reg(REG_CANVAS_WIDTH, 64'd0);
		add_reg(REG_CANVAS_HEIGHT, 64'h7FFF);
		for (int k = 0; k < 3; k++)
			add_pixel(32'h5A5A5A5A, 32'hA5A5A5A5, 1'b0, '0, 1'b0);
		// shrink height below the row counter
		add_reg(REG_CANVAS_HEIGHT, 64'd0);
		add_pixel(32'h01020304, 32'h05060708, 1'b0, '0, 1'b0);
		// shrink width below the column counter
		add_reg(REG_CANVAS_WIDTH, 64'h7FFF);
		add_reg(REG_CANVAS_HEIGHT, 64'd1);
		for (int k = 0; k < 4; k++)
			add_pixel(32'hC0FFEE00 + k, 32'h00C0FFEE, 1'b0, '0, 1'b0);
		add_reg(REG_CANVAS_WIDTH, 64'd2);
		add_pixel(32'h0BADF00D, 32'h00000000, 1'b0, '0, 1'b0);
		// rectangle wholly beyond the canvas on a key frame
		add_reg(REG_CURRENT_RECT, '1);
		add_reg(REG_FRAME_FLAGS, mk_flags(1'b1, 1'b1, 1'b1, 1'b1));
		add_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_REG)
				write_reg(directed_rows[r].index, directed_rows[r].data);
			else
				send_pixel(directed_rows[r].prev_px, directed_rows[r].dec_px,
					directed_rows[r].typed, directed_rows[r].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			send_idle_pct = phase_idle[phase];
			stall_pct <= phase_stall[phase];
			for (int seg = 0; seg < 8; seg++) begin
				case ($urandom_range(0, 11))
					0: w_raw = '0;
					1: w_raw = CANVAS_MAX;
					2: w_raw = '1;
					3: w_raw = 15'($urandom);
					default: w_raw = 15'($urandom_range(1, 8));
				endcase
				case ($urandom_range(0, 11))
					0: h_raw = '0;
					1: h_raw = CANVAS_MAX;
					2: h_raw = '1;
					3: h_raw = 15'($urandom);
					default: h_raw = 15'($urandom_range(1, 6));
				endcase
				span_w = (w_raw == 0) ? 1 : (w_raw > 20 ? 20 : w_raw);
				span_h = (h_raw == 0) ? 1 : (h_raw > 20 ? 20 : h_raw);

				data = {$urandom, $urandom};
				data[SIZE_W-1:0] = w_raw;
				write_reg(REG_CANVAS_WIDTH, data);
				data = {$urandom, $urandom};
				data[SIZE_W-1:0] = h_raw;
				write_reg(REG_CANVAS_HEIGHT, data);
				cur_r = random_rect(span_w, span_h);
				write_reg(REG_CURRENT_RECT, cur_r);
				// same rectangle often enough to hit the fully covered case
				write_reg(REG_PREVIOUS_RECT,
					($urandom_range(0, 3) == 0) ? cur_r : random_rect(span_w, span_h));
				data = {$urandom, $urandom};
				write_reg(REG_FRAME_FLAGS, data);
				if ($urandom_range(0, 3) == 0)
					write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_FLAGS + 1, REG_UNMAPPED)),
						{$urandom, $urandom});

				// hold off the receiver while requests keep coming
				if (phase == 0 && seg == 3)
					holdoff_req <= holdoff_req + 1;

				n = $urandom_range(25, 55);
				for (int i = 0; i < n; i++) begin
					prev_px = $urandom;
					dec_px = $urandom;
					case ($urandom_range(0, 3))
						0: dec_px[31:24] = 8'h00;
						1: dec_px[31:24] = 8'hFF;
						default: ;
					endcase
					send_pixel(prev_px, dec_px, 1'b0, '0);
				end
			end
		end

		drain();
		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
